>>> hw/rtl/crg_pkg.sv
`default_nettype none

package crg_pkg;

    // Default fraction bits of the Q-format values
    localparam int FRAC_BITS_DEF = 12;

    // Register index map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORWARD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS    = 3'd5;

    // Register reset values
    localparam logic [47:0] RST_POSITION = 48'd17592186044416;
    localparam logic [47:0] RST_FORWARD  = 48'd263882790666240;
    localparam logic [47:0] RST_UP       = 48'd268435456;
    localparam logic [47:0] RST_RIGHT    = 48'd4096;
    localparam logic [15:0] RST_FOCUS    = 16'd4096;

    // Widths of the normalized direction path
    localparam int MAG_W  = 31;
    localparam int ROOT_W = 31;
    localparam int LEN2_W = 62;

    typedef struct packed {
        logic        mode;
        logic [47:0] position;
        logic [47:0] forward;
        logic [47:0] up;
        logic [47:0] right;
        logic [15:0] focus;
    } t_cfg;

    typedef struct packed {
        logic            mode;
        logic            zero;
        logic [2:0][15:0] org;
    } t_side;

    typedef struct packed {
        t_side                 side;
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } t_carry;

    // Pick one signed 16-bit component out of a packed vector
    function automatic logic signed [15:0] comp16(input logic [47:0] p, input int k);
        comp16 = p[16*k +: 16];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/camera_ray_generation_core.sv
// Pinhole camera primary ray generator.
// Input channel: i_in_valid / o_in_stall carrying i_screen_x, i_screen_y (signed
// fixed point with FRAC_BITS fraction bits). An item is taken at an edge with
// i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carrying one ray per item: origin,
// direction and the zero_length flag, taken at an edge with i_out_stall low.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) with a register index
// and 48-bit data; write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// is the 7-stage multiply and normalize front end, then the 31-stage square
// root, then the FRAC_BITS + 2 stage divider.
// When i_out_stall holds a valid result, the whole pipeline freezes and
// o_in_stall rises in the same cycle; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the default
// camera: perspective, at z = 1 looking down -z, up +y, right +x, focus 1.
`default_nettype none

module camera_ray_generation_core #(
    parameter int FRAC_BITS = crg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [15:0]             i_screen_x,
    input  wire logic signed [15:0]             i_screen_y,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [15:0]                  o_origin_x,
    output logic signed [15:0]                  o_origin_y,
    output logic signed [15:0]                  o_origin_z,
    output logic signed [15:0]                  o_dir_x,
    output logic signed [15:0]                  o_dir_y,
    output logic signed [15:0]                  o_dir_z,
    output logic                                o_zero_length,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [crg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [47:0]                    i_cfg_data
);
    import crg_pkg::*;

    localparam int EW = (FRAC_BITS + 2) > 17 ? (FRAC_BITS + 2) : 17;
    localparam logic signed [EW-1:0] SMAX = EW'(32767);
    localparam logic signed [EW-1:0] SMIN = -SMAX - EW'(1);

    // Configuration registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode     <= 1'b0;
            r_cfg.position <= RST_POSITION;
            r_cfg.forward  <= RST_FORWARD;
            r_cfg.up       <= RST_UP;
            r_cfg.right    <= RST_RIGHT;
            r_cfg.focus    <= RST_FOCUS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:     r_cfg.mode     <= i_cfg_data[0];
                CFG_POSITION: r_cfg.position <= i_cfg_data;
                CFG_FORWARD:  r_cfg.forward  <= i_cfg_data;
                CFG_UP:       r_cfg.up       <= i_cfg_data;
                CFG_RIGHT:    r_cfg.right    <= i_cfg_data;
                CFG_FOCUS:    r_cfg.focus    <= i_cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Advance the whole pipeline unless a held result is stalled
    logic r_out_valid;
    logic pipe_en;

    assign pipe_en    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !pipe_en;

    logic              fr_valid;
    logic [LEN2_W-1:0] fr_len2;
    t_carry            fr_carry;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_carry            sq_carry;
    logic              dv_valid;
    logic [2:0][FRAC_BITS:0] dv_q;
    t_carry            dv_carry;

    crg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (i_in_valid),
        .i_x     (i_screen_x),
        .i_y     (i_screen_y),
        .i_cfg   (r_cfg),
        .o_valid (fr_valid),
        .o_len2  (fr_len2),
        .o_carry (fr_carry)
    );

    crg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (fr_valid),
        .i_len2  (fr_len2),
        .i_carry (fr_carry),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_carry (sq_carry)
    );

    crg_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_carry (sq_carry),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_carry (dv_carry)
    );

    // Final stage: apply sign, saturate, select by mode
    logic signed [EW-1:0] n_sv  [3];
    logic signed [15:0]   n_dir [3];
    logic                 n_zero;

    always_comb begin
        n_zero = !dv_carry.side.mode && dv_carry.side.zero;
        for (int k = 0; k < 3; k++) begin
            n_sv[k] = dv_carry.neg[k] ? -$signed(EW'(dv_q[k])) : $signed(EW'(dv_q[k]));
            if (dv_carry.side.mode) begin
                n_dir[k] = comp16(r_cfg.forward, k);
            end else if (n_zero) begin
                n_dir[k] = '0;
            end else if (n_sv[k] > SMAX) begin
                n_dir[k] = 16'sh7FFF;
            end else if (n_sv[k] < SMIN) begin
                n_dir[k] = -16'sh7FFF - 16'sd1;
            end else begin
                n_dir[k] = n_sv[k][15:0];
            end
        end
    end

    logic signed [15:0] r_org [3];
    logic signed [15:0] r_dir [3];
    logic               r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= dv_carry.side.org[k];
                r_dir[k] <= n_dir[k];
            end
            r_zero <= n_zero;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_origin_x    = r_org[0];
    assign o_origin_y    = r_org[1];
    assign o_origin_z    = r_org[2];
    assign o_dir_x       = r_dir[0];
    assign o_dir_y       = r_dir[1];
    assign o_dir_z       = r_dir[2];
    assign o_zero_length = r_zero;

endmodule

`default_nettype wire

>>> hw/rtl/crg_front.sv
`default_nettype none

module crg_front #(
    parameter int FRAC_BITS = crg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic signed [15:0]          i_x,
    input  wire logic signed [15:0]          i_y,
    input  wire crg_pkg::t_cfg               i_cfg,
    output logic                             o_valid,
    output logic [crg_pkg::LEN2_W-1:0]       o_len2,
    output crg_pkg::t_carry                  o_carry
);
    import crg_pkg::*;

    localparam int V_W = 33;
    localparam int AW  = ((FRAC_BITS + 16) > 32 ? (FRAC_BITS + 16) : 32) + 2;
    localparam logic signed [AW-1:0] RND    = AW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SMAX_A = AW'(32767);
    localparam logic signed [AW-1:0] SMIN_A = -SMAX_A - AW'(1);
    localparam logic [31:0] HI = 32'd1 << 30;

    // Stage 1: the nine products
    logic                r_s1_valid;
    logic                r_s1_mode;
    logic signed [31:0]  r_s1_pf [3];
    logic signed [31:0]  r_s1_pu [3];
    logic signed [31:0]  r_s1_pr [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_mode <= i_cfg.mode;
            for (int k = 0; k < 3; k++) begin
                r_s1_pf[k] <= 32'(comp16(i_cfg.forward, k)) * 32'($signed(i_cfg.focus));
                r_s1_pu[k] <= 32'(comp16(i_cfg.up, k)) * 32'(i_y);
                r_s1_pr[k] <= 32'(comp16(i_cfg.right, k)) * 32'(i_x);
            end
        end
    end

    // Stage 2: direction sums and the finished origin
    logic                r_s2_valid;
    logic signed [V_W-1:0] r_s2_v [3];
    t_side               r_s2_side;
    logic signed [V_W-1:0] n_s2_v [3];
    t_side               n_s2_side;
    logic signed [AW-1:0]  n_acc [3];
    logic signed [AW-1:0]  n_sh  [3];

    always_comb begin
        n_s2_side.mode = r_s1_mode;
        n_s2_side.zero = 1'b0;
        for (int k = 0; k < 3; k++) begin
            n_s2_v[k] = V_W'(r_s1_pf[k]) + V_W'(r_s1_pu[k]) + V_W'(r_s1_pr[k]);
            n_acc[k]  = (AW'(comp16(i_cfg.position, k)) <<< FRAC_BITS)
                      + AW'(r_s1_pr[k]) + AW'(r_s1_pu[k]) + RND;
            n_sh[k]   = n_acc[k] >>> FRAC_BITS;
            if (!r_s1_mode) begin
                n_s2_side.org[k] = comp16(i_cfg.position, k);
            end else if (n_sh[k] > SMAX_A) begin
                n_s2_side.org[k] = 16'h7FFF;
            end else if (n_sh[k] < SMIN_A) begin
                n_s2_side.org[k] = 16'h8000;
            end else begin
                n_s2_side.org[k] = n_sh[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_v    <= n_s2_v;
            r_s2_side <= n_s2_side;
        end
    end

    // Stage 3: largest magnitude
    logic                r_s3_valid;
    logic signed [V_W-1:0] r_s3_v [3];
    logic [31:0]         r_s3_mx;
    t_side               r_s3_side;
    logic [31:0]         n_mag [3];
    logic [31:0]         n_mx;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_s2_v[k][V_W-1] ? 32'(-r_s2_v[k]) : 32'(r_s2_v[k]);
        end
        n_mx = n_mag[0];
        if (n_mag[1] > n_mx) begin
            n_mx = n_mag[1];
        end
        if (n_mag[2] > n_mx) begin
            n_mx = n_mag[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_v    <= r_s2_v;
            r_s3_mx   <= n_mx;
            r_s3_side <= r_s2_side;
        end
    end

    // Stage 4: pick the shift that brings the largest magnitude to [2^29, 2^30]
    logic                r_s4_valid;
    logic signed [V_W-1:0] r_s4_v [3];
    logic [1:0]          r_s4_rs;
    logic [4:0]          r_s4_ls;
    t_side               r_s4_side;
    logic [1:0]          n_rs;
    logic [4:0]          n_msb;
    logic [4:0]          n_ls;
    t_side               n_s4_side;

    always_comb begin
        n_msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_s3_mx[b]) begin
                n_msb = 5'(b);
            end
        end
        n_ls = (n_msb >= 5'd29) ? 5'd0 : 5'd29 - n_msb;
        if (r_s3_mx <= HI) begin
            n_rs = 2'd0;
        end else if ((r_s3_mx >> 1) <= HI) begin
            n_rs = 2'd1;
        end else begin
            n_rs = 2'd2;
        end
        n_s4_side      = r_s3_side;
        n_s4_side.zero = (r_s3_mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_v    <= r_s3_v;
            r_s4_rs   <= n_rs;
            r_s4_ls   <= n_ls;
            r_s4_side <= n_s4_side;
        end
    end

    // Stage 5: apply the shift, right shifts floor
    logic               r_s5_valid;
    logic signed [31:0] r_s5_vn [3];
    t_side              r_s5_side;
    logic signed [31:0] n_vn [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_s4_rs != 2'd0) begin
                n_vn[k] = 32'(r_s4_v[k] >>> r_s4_rs);
            end else begin
                n_vn[k] = 32'(r_s4_v[k] <<< r_s4_ls);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (i_en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5_vn   <= n_vn;
            r_s5_side <= r_s4_side;
        end
    end

    // Stage 6: squares, magnitudes and signs
    logic               r_s6_valid;
    logic [60:0]        r_s6_sq [3];
    t_carry             r_s6_carry;
    logic signed [63:0] n_sq64 [3];
    t_carry             n_s6_carry;
    logic signed [31:0] n_neg_v [3];

    always_comb begin
        n_s6_carry.side = r_s5_side;
        for (int k = 0; k < 3; k++) begin
            n_sq64[k]  = 64'(r_s5_vn[k]) * 64'(r_s5_vn[k]);
            n_neg_v[k] = -r_s5_vn[k];
            n_s6_carry.neg[k] = r_s5_vn[k][31];
            n_s6_carry.mag[k] = r_s5_vn[k][31] ? n_neg_v[k][MAG_W-1:0]
                                               : r_s5_vn[k][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (i_en) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_s6_sq[k] <= n_sq64[k][60:0];
            end
            r_s6_carry <= n_s6_carry;
        end
    end

    // Stage 7: squared length
    logic              r_s7_valid;
    logic [LEN2_W-1:0] r_s7_len2;
    t_carry            r_s7_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (i_en) begin
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s7_len2  <= LEN2_W'(r_s6_sq[0]) + LEN2_W'(r_s6_sq[1]) + LEN2_W'(r_s6_sq[2]);
            r_s7_carry <= r_s6_carry;
        end
    end

    assign o_valid = r_s7_valid;
    assign o_len2  = r_s7_len2;
    assign o_carry = r_s7_carry;

endmodule

`default_nettype wire

>>> hw/rtl/crg_isqrt.sv
`default_nettype none

module crg_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [crg_pkg::LEN2_W-1:0]  i_len2,
    input  wire crg_pkg::t_carry             i_carry,
    output logic                             o_valid,
    output logic [crg_pkg::ROOT_W-1:0]       o_root,
    output crg_pkg::t_carry                  o_carry
);
    import crg_pkg::*;

    localparam int NS = ROOT_W;

    logic              r_valid [NS];
    logic [31:0]       r_rem   [NS];
    logic [ROOT_W-1:0] r_root  [NS];
    logic [LEN2_W-1:0] r_n     [NS];
    t_carry            r_carry [NS];

    // One root bit per stage, most significant first
    for (genvar g = 0; g < NS; g++) begin : g_stage
        localparam int I = NS - 1 - g;
        logic              p_valid;
        logic [31:0]       p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [LEN2_W-1:0] p_n;
        t_carry            p_carry;
        logic [33:0]       rem_t;
        logic [33:0]       trial;
        logic [33:0]       diff;
        logic              take;

        if (g == 0) begin : g_first
            assign p_valid = i_valid;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_n     = i_len2;
            assign p_carry = i_carry;
        end else begin : g_next
            assign p_valid = r_valid[g-1];
            assign p_rem   = r_rem[g-1];
            assign p_root  = r_root[g-1];
            assign p_n     = r_n[g-1];
            assign p_carry = r_carry[g-1];
        end

        assign rem_t = {p_rem, p_n[2*I+1 -: 2]};
        assign trial = {1'b0, p_root, 2'b01};
        assign take  = (rem_t >= trial);
        assign diff  = rem_t - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]   <= take ? diff[31:0] : rem_t[31:0];
                r_root[g]  <= {p_root[ROOT_W-2:0], take};
                r_n[g]     <= p_n;
                r_carry[g] <= p_carry;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_carry = r_carry[NS-1];

endmodule

`default_nettype wire

>>> hw/rtl/crg_div.sv
`default_nettype none

module crg_div #(
    parameter int FRAC_BITS = crg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [crg_pkg::ROOT_W-1:0]  i_root,
    input  wire crg_pkg::t_carry             i_carry,
    output logic                             o_valid,
    output logic [2:0][FRAC_BITS:0]          o_q,
    output crg_pkg::t_carry                  o_carry
);
    import crg_pkg::*;

    localparam int NW = FRAC_BITS + 32;
    localparam int QW = FRAC_BITS + 1;

    // Prep stage: rounded numerator and the first partial remainder
    logic              r_p_valid;
    logic [NW-1:0]     r_p_num [3];
    logic [MAG_W-1:0]  r_p_rm  [3];
    logic [ROOT_W-1:0] r_p_root;
    t_carry            r_p_carry;
    logic [NW-1:0]     n_num   [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num[k] = (NW'(i_carry.mag[k]) << FRAC_BITS) + NW'(i_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p_num[k] <= n_num[k];
                r_p_rm[k]  <= n_num[k][NW-1:FRAC_BITS+1];
            end
            r_p_root  <= i_root;
            r_p_carry <= i_carry;
        end
    end

    logic              r_valid [QW];
    logic [NW-1:0]     r_num   [QW][3];
    logic [MAG_W-1:0]  r_rm    [QW][3];
    logic [QW-1:0]     r_q     [QW][3];
    logic [ROOT_W-1:0] r_root  [QW];
    t_carry            r_carry [QW];

    // One quotient bit per stage in each of the three lanes
    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int B = FRAC_BITS - g;
        logic              p_valid;
        logic [NW-1:0]     p_num [3];
        logic [MAG_W-1:0]  p_rm  [3];
        logic [QW-1:0]     p_q   [3];
        logic [ROOT_W-1:0] p_root;
        t_carry            p_carry;
        logic [MAG_W:0]    rt    [3];
        logic [MAG_W:0]    diff  [3];
        logic              take  [3];

        if (g == 0) begin : g_first
            assign p_valid = r_p_valid;
            assign p_num   = r_p_num;
            assign p_rm    = r_p_rm;
            assign p_q     = '{default: '0};
            assign p_root  = r_p_root;
            assign p_carry = r_p_carry;
        end else begin : g_next
            assign p_valid = r_valid[g-1];
            assign p_num   = r_num[g-1];
            assign p_rm    = r_rm[g-1];
            assign p_q     = r_q[g-1];
            assign p_root  = r_root[g-1];
            assign p_carry = r_carry[g-1];
        end

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                rt[k]   = {p_rm[k], p_num[k][B]};
                take[k] = (rt[k] >= {1'b0, p_root});
                diff[k] = rt[k] - {1'b0, p_root};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= p_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_num[g][k] <= p_num[k];
                    r_rm[g][k]  <= take[k] ? diff[k][MAG_W-1:0] : rt[k][MAG_W-1:0];
                    r_q[g][k]   <= {p_q[k][QW-2:0], take[k]};
                end
                r_root[g]  <= p_root;
                r_carry[g] <= p_carry;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_carry = r_carry[QW-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_q[k] = r_q[QW-1][k];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/crg_checker.sv
`default_nettype none

module crg_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_stall,
    input  wire logic signed [15:0]             i_screen_x,
    input  wire logic signed [15:0]             i_screen_y,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic signed [15:0]             o_origin_x,
    input  wire logic signed [15:0]             o_origin_y,
    input  wire logic signed [15:0]             o_origin_z,
    input  wire logic signed [15:0]             o_dir_x,
    input  wire logic signed [15:0]             o_dir_y,
    input  wire logic signed [15:0]             o_dir_z,
    input  wire logic                           o_zero_length,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           o_cfg_ready,
    input  wire logic [crg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [47:0]                    i_cfg_data
);

    // Hold a stalled ray: valid, the direction and origin_x stay stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dir_x)
            && $stable(o_dir_y) && $stable(o_dir_z) && $stable(o_origin_x))
        else $error("stalled ray changed");

    // A stalled full output must back up into the input
    a_backpressure: assert property (@(posedge i_clk)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output stalled");

    // An empty output never stalls the input
    a_no_bubble_stall: assert property (@(posedge i_clk)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // Zero-length rays carry a zero direction
    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |-> o_dir_x == 16'sd0 && o_dir_y == 16'sd0
            && o_dir_z == 16'sd0)
        else $error("zero-length ray has nonzero direction");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind camera_ray_generation_core crg_checker u_crg_checker (.*);

`default_nettype wire

>>> dv/tb_camera_ray_generation_core.sv
`default_nettype none

module tb_camera_ray_generation_core;
    timeunit 1ns;
    timeprecision 1ps;

    import crg_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int LATENCY    = FB + 41;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_PHASES   = 16;
    localparam int PHASE_ITEMS = 95;

    typedef struct {
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic signed [15:0] org_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               zero_len;
    } ray_t;

    typedef struct {
        int                 setup;
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        ray_t               ray;
    } dir_row_t;

    // Directed setups
    typedef enum int {SET_DEFAULT, SET_ORTHO, SET_FOCUS_ZERO, SET_SAT} setup_e;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [15:0]   i_screen_x;
    logic signed [15:0]   i_screen_y;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [15:0]   o_origin_x;
    logic signed [15:0]   o_origin_y;
    logic signed [15:0]   o_origin_z;
    logic signed [15:0]   o_dir_x;
    logic signed [15:0]   o_dir_y;
    logic signed [15:0]   o_dir_z;
    logic                 o_zero_length;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [47:0]          i_cfg_data;

    camera_ray_generation_core u_dut (.*);

    // Camera shadow registers
    logic        cam_mode;
    logic [47:0] cam_pos;
    logic [47:0] cam_fwd;
    logic [47:0] cam_up;
    logic [47:0] cam_right;
    logic [15:0] cam_focus;

    ray_t ray_q[$];
    int   fail_cnt;
    int   idle_cnt;
    bit   in_calm;
    bit   out_calm;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint vcomp(input logic [47:0] p, input int k);
        logic signed [15:0] c;
        c = p[16*k +: 16];
        return longint'(c);
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Compute the ray for one coordinate pair under the shadow camera
    function automatic ray_t trace_ray(input logic signed [15:0] sx,
                                       input logic signed [15:0] sy);
        longint      x, y, f, acc, mx, q, m;
        longint      v[3];
        logic [63:0] len2, r, num;
        longint      o[3], d[3];
        ray_t        rr;
        x = sx;
        y = sy;
        rr.zero_len = 1'b0;
        if (cam_mode) begin
            for (int k = 0; k < 3; k++) begin
                acc = vcomp(cam_pos, k) * (64'sd1 <<< FB) + vcomp(cam_right, k) * x
                    + vcomp(cam_up, k) * y + (64'sd1 <<< (FB - 1));
                o[k] = sat16(acc >>> FB);
                d[k] = vcomp(cam_fwd, k);
            end
        end else begin
            f  = longint'($signed(cam_focus));
            mx = 0;
            for (int k = 0; k < 3; k++) begin
                o[k] = vcomp(cam_pos, k);
                v[k] = vcomp(cam_fwd, k) * f + vcomp(cam_up, k) * y
                     + vcomp(cam_right, k) * x;
                m = (v[k] < 0) ? -v[k] : v[k];
                if (m > mx) mx = m;
            end
            if (mx == 0) begin
                for (int k = 0; k < 3; k++) d[k] = 0;
                rr.zero_len = 1'b1;
            end else begin
                while (mx > (64'sd1 <<< 30)) begin
                    for (int k = 0; k < 3; k++) v[k] = v[k] >>> 1;
                    mx = mx >>> 1;
                end
                while (mx < (64'sd1 <<< 29)) begin
                    for (int k = 0; k < 3; k++) v[k] = v[k] * 2;
                    mx = mx * 2;
                end
                len2 = 0;
                for (int k = 0; k < 3; k++) len2 = len2 + 64'(v[k] * v[k]);
                r = floor_root(len2);
                for (int k = 0; k < 3; k++) begin
                    m   = (v[k] < 0) ? -v[k] : v[k];
                    num = 64'(m) << FB;
                    q   = longint'((num + (r >> 1)) / r);
                    d[k] = sat16((v[k] < 0) ? -q : q);
                end
            end
        end
        rr.org_x = o[0][15:0];
        rr.org_y = o[1][15:0];
        rr.org_z = o[2][15:0];
        rr.dir_x = d[0][15:0];
        rr.dir_y = d[1][15:0];
        rr.dir_z = d[2][15:0];
        return rr;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Check each accepted ray against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ray_t e;
            if (ray_q.size() == 0) begin
                $error("ray with no expectation waiting");
                fail_cnt++;
            end else begin
                e = ray_q.pop_front();
                if (o_origin_x !== e.org_x) begin
                    $error("origin_x exp %0d got %0d", e.org_x, o_origin_x); fail_cnt++;
                end
                if (o_origin_y !== e.org_y) begin
                    $error("origin_y exp %0d got %0d", e.org_y, o_origin_y); fail_cnt++;
                end
                if (o_origin_z !== e.org_z) begin
                    $error("origin_z exp %0d got %0d", e.org_z, o_origin_z); fail_cnt++;
                end
                if (o_dir_x !== e.dir_x) begin
                    $error("dir_x exp %0d got %0d", e.dir_x, o_dir_x); fail_cnt++;
                end
                if (o_dir_y !== e.dir_y) begin
                    $error("dir_y exp %0d got %0d", e.dir_y, o_dir_y); fail_cnt++;
                end
                if (o_dir_z !== e.dir_z) begin
                    $error("dir_z exp %0d got %0d", e.dir_z, o_dir_z); fail_cnt++;
                end
                if (o_zero_length !== e.zero_len) begin
                    $error("zero_length exp %0d got %0d", e.zero_len, o_zero_length);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive receiver stall with runs of random length
    initial begin
        int cnt;
        cnt = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_calm) begin
                i_out_stall = 1'b0;
            end else if (cnt > 0) begin
                cnt--;
            end else if (i_out_stall) begin
                i_out_stall = 1'b0;
                cnt = $urandom_range(12);
            end else begin
                cnt = gap_len();
                i_out_stall = (cnt > 0);
                if (cnt > 0) cnt--;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:     cam_mode  = data[0];
            CFG_POSITION: cam_pos   = data;
            CFG_FORWARD:  cam_fwd   = data;
            CFG_UP:       cam_up    = data;
            CFG_RIGHT:    cam_right = data;
            CFG_FOCUS:    cam_focus = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Send one coordinate pair; hold valid high for back-to-back items
    task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                             input bit typed, input ray_t ray);
        int g;
        g = in_calm ? 0 : gap_len();
        repeat (g) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_screen_x = x;
        i_screen_y = y;
        do @(posedge i_clk); while (o_in_stall);
        ray_q.push_back(typed ? ray : trace_ray(x, y));
    endtask

    // Drop valid, wait out all rays in flight, then leave the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ray_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_vec();
        int p;
        logic [47:0] v;
        p = $urandom_range(9);
        v = 48'({$urandom, $urandom});
        case (p)
            0: v = {16'h7FFF, 16'h7FFF, 16'h7FFF};
            1: v = {16'h8000, 16'h8000, 16'h8000};
            2: v = 48'd0;
            3, 4, 5: v = {16'($signed($urandom_range(8192)) - 4096),
                          16'($signed($urandom_range(8192)) - 4096),
                          16'($signed($urandom_range(8192)) - 4096)};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        int p;
        p = $urandom_range(9);
        case (p)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sd0;
            3, 4, 5: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    dir_row_t dir_tab[] = '{
        '{SET_DEFAULT, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 1'b0}},
        '{SET_DEFAULT, 16'sh7FFF, 16'sh7FFF, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_DEFAULT, 16'sh8000, 16'sh8000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_DEFAULT, 16'sh8000, 16'sh7FFF, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_DEFAULT, 16'sd4096, 16'sd0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_DEFAULT, 16'sd0, -16'sd4096, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_DEFAULT, 16'sd1, -16'sd1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_ORTHO, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 1'b0}},
        '{SET_ORTHO, 16'sh7FFF, 16'sd0, 1'b1,
          '{16'sd32767, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 1'b0}},
        '{SET_ORTHO, 16'sh8000, 16'sh8000, 1'b1,
          '{-16'sd32768, -16'sd32768, 16'sd4096, 16'sd0, 16'sd0, -16'sd4096, 1'b0}},
        '{SET_ORTHO, 16'sd2048, -16'sd1, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_FOCUS_ZERO, 16'sd0, 16'sd0, 1'b1,
          '{16'sd0, 16'sd0, 16'sd4096, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{SET_FOCUS_ZERO, 16'sd5, 16'sd0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_FOCUS_ZERO, 16'sh7FFF, 16'sh8000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_SAT, 16'sh7FFF, 16'sh7FFF, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_SAT, 16'sh8000, 16'sh8000, 1'b0, '{0, 0, 0, 0, 0, 0, 0}},
        '{SET_SAT, 16'sd0, 16'sd0, 1'b0, '{0, 0, 0, 0, 0, 0, 0}}
    };

    initial begin
        int cur_setup;
        ray_t none;
        none = '{0, 0, 0, 0, 0, 0, 0};
        fail_cnt    = 0;
        idle_cnt    = 0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_screen_x  = '0;
        i_screen_y  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cam_mode  = 1'b0;
        cam_pos   = RST_POSITION;
        cam_fwd   = RST_FORWARD;
        cam_up    = RST_UP;
        cam_right = RST_RIGHT;
        cam_focus = RST_FOCUS;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows, reconfiguring when the setup column changes
        cur_setup = SET_DEFAULT;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].setup != cur_setup) begin
                drain();
                cur_setup = dir_tab[i].setup;
                case (cur_setup)
                    SET_ORTHO: write_reg(CFG_MODE, 48'hFFFF_FFFF_FFFF);
                    SET_FOCUS_ZERO: begin
                        write_reg(CFG_MODE, 48'hFFFF_FFFF_FFFE);
                        write_reg(CFG_FOCUS, 48'hABCD_0000_0000);
                    end
                    default: begin
                        write_reg(CFG_POSITION, {16'h7FFF, 16'h8000, 16'h7FFF});
                        write_reg(CFG_FORWARD, {16'h8000, 16'h8000, 16'h8000});
                        write_reg(CFG_UP, {16'h7FFF, 16'h7FFF, 16'h7FFF});
                        write_reg(CFG_RIGHT, {16'h8000, 16'h7FFF, 16'h8000});
                        write_reg(CFG_FOCUS, 48'h0000_0000_8000);
                        write_reg(3'd6, 48'h5555_5555_5555);
                        write_reg(3'd7, 48'hAAAA_AAAA_AAAA);
                    end
                endcase
            end
            send_pair(dir_tab[i].x, dir_tab[i].y, dir_tab[i].typed,
                      dir_tab[i].typed ? dir_tab[i].ray : none);
        end

        // Random phases, each under a new camera
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            in_calm  = ($urandom_range(5) == 0);
            out_calm = ($urandom_range(5) == 0);
            write_reg(CFG_MODE, 48'({$urandom, $urandom}));
            if (ph == N_PHASES - 1) write_reg(CFG_MODE, 48'hFFFF_FFFF_FFFF);
            if ($urandom_range(1)) write_reg(CFG_POSITION, rand_vec());
            write_reg(CFG_FORWARD, rand_vec());
            if ($urandom_range(1)) write_reg(CFG_UP, rand_vec());
            if ($urandom_range(1)) write_reg(CFG_RIGHT, rand_vec());
            case ($urandom_range(5))
                0: write_reg(CFG_FOCUS, {$urandom, 16'h7FFF});
                1: write_reg(CFG_FOCUS, {$urandom, 16'h8000});
                2: write_reg(CFG_FOCUS, {$urandom, 16'h0000});
                default: write_reg(CFG_FOCUS, 48'({$urandom, $urandom}));
            endcase
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(7, 6)), 48'({$urandom, $urandom}));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pair(rand_coord(), rand_coord(), 1'b0, none);
        end

        // Let everything drain and watch for stray rays
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ray_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_cnt == 0 && ray_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/crg_pkg.sv
hw/rtl/crg_front.sv
hw/rtl/crg_isqrt.sv
hw/rtl/crg_div.sv
hw/rtl/camera_ray_generation_core.sv
hw/rtl/crg_checker.sv
dv/tb_camera_ray_generation_core.sv
